// ===== design/eft_pkg.sv =====
// eft_pkg: shared types, constants and helpers for the ellipse fan tessellator
// used by eft_cordic and ellipse_fan_tessellator_top; no dependencies
package eft_pkg;

    localparam int MaxSlicesDef = 64;

    // widths of the stream payloads
    localparam int InDataW  = 168;
    localparam int OutDataW = 144;

    // Q4.30 cordic start value (unit vector scaled by the inverse cordic gain)
    localparam logic signed [33:0] CordicGain = 34'sd652032875;
    // rotation scale: 65536 * 16 / (2*pi), rounded
    localparam logic signed [18:0] RotScale = 19'sd166886;
    // unit length in Q2.14
    localparam logic signed [15:0] UnitQ14 = 16'sd16384;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROT_START,
        ST_ROT_WAIT,
        ST_PT_START,
        ST_PT_WAIT,
        ST_PT_MUL,
        ST_PT_SUM,
        ST_EMIT
    } eft_state_t;

    // cordic unit states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RUN,
        CS_DONE
    } cordic_state_t;

    // request into the cordic unit
    typedef struct packed {
        logic        start;
        logic [15:0] phase;
    } cordic_req_t;

    // response from the cordic unit
    typedef struct packed {
        logic               done;
        logic signed [15:0] cos_val;
        logic signed [15:0] sin_val;
    } cordic_rsp_t;

    // arctangent of 2^-k in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [3:0] k);
        logic [29:0] v;
        begin
            case (k)
                4'd0:    v = 30'd536870912;
                4'd1:    v = 30'd316933406;
                4'd2:    v = 30'd167458907;
                4'd3:    v = 30'd85004756;
                4'd4:    v = 30'd42667331;
                4'd5:    v = 30'd21354465;
                4'd6:    v = 30'd10679838;
                4'd7:    v = 30'd5340245;
                4'd8:    v = 30'd2670163;
                4'd9:    v = 30'd1335087;
                4'd10:   v = 30'd667544;
                4'd11:   v = 30'd333772;
                4'd12:   v = 30'd166886;
                4'd13:   v = 30'd83443;
                4'd14:   v = 30'd41722;
                default: v = 30'd20861;
            endcase
            return v;
        end
    endfunction

    // saturate to 32-bit signed
    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        begin
            if (v > 37'sd2147483647) r = 32'h7FFF_FFFF;
            else if (v < -37'sd2147483648) r = 32'h8000_0000;
            else r = v[31:0];
            return r;
        end
    endfunction

    // clamp a rounded cordic output to [-1, 1] in Q2.14
    function automatic logic signed [15:0] clamp_unit(input logic signed [17:0] v);
        logic signed [15:0] r;
        begin
            if (v > 18'sd16384) r = UnitQ14;
            else if (v < -18'sd16384) r = -UnitQ14;
            else r = v[15:0];
            return r;
        end
    endfunction

endpackage

// ===== design/eft_cordic.sv =====
// eft_cordic: iterative 16-step cordic giving cosine and sine of a 16-bit phase
// depends on eft_pkg
module eft_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  eft_pkg::cordic_req_t req_i,
    output eft_pkg::cordic_rsp_t rsp_o
);
    import eft_pkg::*;

    cordic_state_t state_reg, state_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic [3:0]         k_reg, k_next;
    logic [1:0]         quad_reg, quad_next;

    logic signed [33:0] xs, ys;
    logic signed [32:0] atan_s;
    logic signed [17:0] xr, yr;
    logic signed [15:0] xc, yc;

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        k_reg    <= k_next;
        quad_reg <= quad_next;
    end

    // shared shift and arctangent lookup for the add-subtract step
    always_comb begin
        xs     = x_reg >>> k_reg;
        ys     = y_reg >>> k_reg;
        atan_s = signed'({3'b000, atan_turn(k_reg)});
    end

    // sequencing
    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        k_next     = k_reg;
        quad_next  = quad_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (req_i.start) begin
                    x_next     = CordicGain;
                    y_next     = '0;
                    z_next     = signed'({3'b000, req_i.phase[13:0], 16'h0000});
                    k_next     = '0;
                    quad_next  = req_i.phase[15:14];
                    state_next = CS_RUN;
                end
            end
            CS_RUN: begin
                if (!z_reg[32]) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_s;
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_s;
                end
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd15) begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE: begin
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // round to Q2.14, clamp and unfold the quadrant
    always_comb begin
        xr = 18'((x_reg + 34'sd32768) >>> 16);
        yr = 18'((y_reg + 34'sd32768) >>> 16);
        xc = clamp_unit(xr);
        yc = clamp_unit(yr);
        rsp_o.done = (state_reg == CS_DONE);
        case (quad_reg)
            2'd0: begin
                rsp_o.cos_val = xc;
                rsp_o.sin_val = yc;
            end
            2'd1: begin
                rsp_o.cos_val = -yc;
                rsp_o.sin_val = xc;
            end
            2'd2: begin
                rsp_o.cos_val = -xc;
                rsp_o.sin_val = -yc;
            end
            default: begin
                rsp_o.cos_val = yc;
                rsp_o.sin_val = -xc;
            end
        endcase
    end

endmodule

// ===== design/ellipse_fan_tessellator_top.sv =====
// ellipse_fan_tessellator_top: turns one ellipse into a fan of rim-point slices
// depends on eft_pkg and eft_cordic
//
//  channel | dir | tdata                                        | tuser      | tlast
//  s_      | in  | center_x,center_y,radius_x,radius_y,          | new_frame  | -
//          |     | turn_angle,slice_count,alpha                 |            |
//  m_      | out | rim_x0,rim_y0,rim_x1,rim_y1,alpha_out        | path_break | last_slice
//
// one request at a time; s_tready is high only while idle
// per shape: the phase-step division, then the rotation sine/cosine when a turn angle is set,
// then one rim point at a time (n+1 points), each through the shared cordic and the shared
// multiplier, with extra multiplier steps when rotating
// a stalled m_ side holds the sequencer in its emit step; reset is synchronous, active low
module ellipse_fan_tessellator_top #(
    parameter int MAX_SLICES = eft_pkg::MaxSlicesDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // center_x[31:0] center_y[63:32] radius_x[94:64] radius_y[125:95]
    // turn_angle[141:126] slice_count[148:142] alpha[164:149] zero[167:165]
    input  logic [eft_pkg::InDataW-1:0]   s_tdata,
    // new_frame[0]
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // rim_x0[31:0] rim_y0[63:32] rim_x1[95:64] rim_y1[127:96] alpha_out[143:128]
    output logic [eft_pkg::OutDataW-1:0]  m_tdata,
    // path_break[0]
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);
    import eft_pkg::*;

    eft_state_t state_reg, state_next;

    // shape registers
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [30:0]        rx_reg, rx_next, ry_reg, ry_next;
    logic [6:0]         n_reg, n_next;
    logic [15:0]        alpha_reg, alpha_next;
    logic               rot_reg, rot_next;
    logic [15:0]        rph_reg, rph_next;
    logic               brk_reg, brk_next;
    logic               started_reg, started_next;

    // phase stepping
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [7:0]  rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [16:0] qacc_reg, qacc_next;
    logic [7:0]  racc_reg, racc_next;
    logic [6:0]  k_reg, k_next;

    // arithmetic
    logic signed [15:0] c_reg, c_next, s_reg, s_next;
    logic signed [15:0] cr_reg, cr_next, sr_reg, sr_next;
    logic signed [52:0] p_reg, p_next;
    logic signed [52:0] acc_reg, acc_next;
    logic signed [35:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [2:0]         step_reg, step_next;
    logic [31:0]        px_reg, px_next, py_reg, py_next;
    logic [31:0]        qx_reg, qx_next, qy_reg, qy_next;

    // output register
    logic               mv_reg, mv_next;
    logic [OutDataW-1:0] md_reg, md_next;
    logic               mb_reg, mb_next, ml_reg, ml_next;

    // shared cordic
    cordic_req_t creq;
    cordic_rsp_t crsp;

    // helpers
    logic signed [35:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [52:0] mul_p;
    logic signed [53:0] diff_w, sum_w;
    logic [6:0]         sc_in, n_in;
    logic signed [34:0] rot_prod;
    logic [7:0]         rem_sh;
    logic [7:0]         rstep;
    logic               out_free;

    eft_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (creq),
        .rsp_o   (crsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mb_reg;
    assign m_tlast  = ml_reg;

    // round half up from Q.14
    function automatic logic signed [35:0] rnd14(input logic signed [53:0] v);
        logic signed [53:0] t;
        begin
            t = (v + 54'sd8192) >>> 14;
            return t[35:0];
        end
    endfunction

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            mv_reg      <= mv_next;
        end
        cx_reg <= cx_next;  cy_reg <= cy_next;
        rx_reg <= rx_next;  ry_reg <= ry_next;
        n_reg <= n_next;    alpha_reg <= alpha_next;
        rot_reg <= rot_next; rph_reg <= rph_next; brk_reg <= brk_next;
        dcnt_reg <= dcnt_next; rem_reg <= rem_next; quo_reg <= quo_next;
        qacc_reg <= qacc_next; racc_reg <= racc_next; k_reg <= k_next;
        c_reg <= c_next; s_reg <= s_next; cr_reg <= cr_next; sr_reg <= sr_next;
        p_reg <= p_next; acc_reg <= acc_next; dx_reg <= dx_next; dy_reg <= dy_next;
        step_reg <= step_next;
        px_reg <= px_next; py_reg <= py_next; qx_reg <= qx_next; qy_reg <= qy_next;
        md_reg <= md_next; mb_reg <= mb_next; ml_reg <= ml_next;
    end

    // multiplier operand selection
    always_comb begin
        case (step_reg)
            3'd0: begin mul_a = signed'({5'b0, rx_reg}); mul_b = 17'(c_reg); end
            3'd1: begin mul_a = signed'({5'b0, ry_reg}); mul_b = 17'(s_reg); end
            3'd3: begin mul_a = dx_reg; mul_b = 17'(cr_reg); end
            3'd4: begin mul_a = dy_reg; mul_b = 17'(sr_reg); end
            3'd5: begin mul_a = dx_reg; mul_b = 17'(sr_reg); end
            3'd6: begin mul_a = dy_reg; mul_b = 17'(cr_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p  = mul_a * mul_b;
        diff_w = 54'(acc_reg) - 54'(p_reg);
        sum_w  = 54'(acc_reg) + 54'(p_reg);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        started_next = started_reg;
        cx_next = cx_reg; cy_next = cy_reg; rx_next = rx_reg; ry_next = ry_reg;
        n_next = n_reg; alpha_next = alpha_reg; rot_next = rot_reg;
        rph_next = rph_reg; brk_next = brk_reg;
        dcnt_next = dcnt_reg; rem_next = rem_reg; quo_next = quo_reg;
        qacc_next = qacc_reg; racc_next = racc_reg; k_next = k_reg;
        c_next = c_reg; s_next = s_reg; cr_next = cr_reg; sr_next = sr_reg;
        p_next = p_reg; acc_next = acc_reg; dx_next = dx_reg; dy_next = dy_reg;
        step_next = step_reg;
        px_next = px_reg; py_next = py_reg; qx_next = qx_reg; qy_next = qy_reg;
        md_next = md_reg; mb_next = mb_reg; ml_next = ml_reg;
        mv_next = mv_reg & ~m_tready;
        out_free = ~mv_reg | m_tready;
        creq.start = 1'b0;
        creq.phase = rph_reg;

        sc_in = s_tdata[148:142];
        n_in  = (32'(sc_in) > MAX_SLICES) ? 7'(MAX_SLICES) : sc_in;
        rot_prod = 35'(signed'(s_tdata[141:126])) * 35'(RotScale) + 35'sd32768;
        rem_sh = {rem_reg[6:0], (dcnt_reg == 5'd16)};
        rstep  = racc_reg + rem_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cx_next    = signed'(s_tdata[31:0]);
                    cy_next    = signed'(s_tdata[63:32]);
                    rx_next    = s_tdata[94:64];
                    ry_next    = s_tdata[125:95];
                    n_next     = n_in;
                    alpha_next = s_tdata[164:149];
                    rot_next   = (s_tdata[141:126] != 16'h0000);
                    rph_next   = rot_prod[31:16];
                    brk_next   = started_reg & ~s_tuser[0];
                    if (s_tuser[0]) started_next = 1'b0;
                    if (n_in != 7'd0) begin
                        started_next = 1'b1;
                        dcnt_next  = 5'd16;
                        rem_next   = '0;
                        quo_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            // one quotient bit of 65536 / n per cycle
            ST_DIV: begin
                if (rem_sh >= {1'b0, n_reg}) begin
                    rem_next = rem_sh - {1'b0, n_reg};
                    quo_next = {quo_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[15:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0) begin
                    qacc_next = '0;
                    racc_next = '0;
                    k_next    = '0;
                    cr_next   = UnitQ14;
                    sr_next   = '0;
                    state_next = rot_reg ? ST_ROT_START : ST_PT_START;
                end
            end
            ST_ROT_START: begin
                creq.start = 1'b1;
                creq.phase = rph_reg;
                state_next = ST_ROT_WAIT;
            end
            ST_ROT_WAIT: begin
                if (crsp.done) begin
                    cr_next = crsp.cos_val;
                    sr_next = crsp.sin_val;
                    state_next = ST_PT_START;
                end
            end
            ST_PT_START: begin
                creq.start = 1'b1;
                creq.phase = qacc_reg[15:0];
                state_next = ST_PT_WAIT;
            end
            ST_PT_WAIT: begin
                if (crsp.done) begin
                    c_next = crsp.cos_val;
                    s_next = crsp.sin_val;
                    step_next = 3'd0;
                    state_next = ST_PT_MUL;
                end
            end
            // scale by the radii, then rotate if a turn angle is set, one product per cycle
            ST_PT_MUL: begin
                p_next = mul_p;
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd1: dx_next = rnd14(54'(p_reg));
                    3'd2: begin
                        dy_next = rnd14(54'(p_reg));
                        if (!rot_reg) state_next = ST_PT_SUM;
                    end
                    3'd4: acc_next = p_reg;
                    3'd5: dx_next = rnd14(diff_w);
                    3'd6: acc_next = p_reg;
                    3'd7: begin
                        dy_next = rnd14(sum_w);
                        state_next = ST_PT_SUM;
                    end
                    default: ;
                endcase
            end
            // add the centre and saturate
            ST_PT_SUM: begin
                qx_next = sat32(37'(cx_reg) + 37'(dx_reg));
                qy_next = sat32(37'(cy_reg) + 37'(dy_reg));
                if (k_reg == 7'd0) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (k_reg == 7'd0 || out_free) begin
                    if (k_reg != 7'd0) begin
                        mv_next = 1'b1;
                        md_next = {alpha_reg, qy_reg, qx_reg, py_reg, px_reg};
                        mb_next = (k_reg == 7'd1) & brk_reg;
                        ml_next = (k_reg == n_reg);
                    end
                    px_next = qx_reg;
                    py_next = qy_reg;
                    if (k_reg == n_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + 7'd1;
                        if (rstep >= {1'b0, n_reg}) begin
                            racc_next = rstep - {1'b0, n_reg};
                            qacc_next = qacc_reg + quo_reg + 17'd1;
                        end else begin
                            racc_next = rstep;
                            qacc_next = qacc_reg + quo_reg;
                        end
                        state_next = ST_PT_START;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
